@@ src/ttk_pkg.sv @@
// shared types, codes and the pattern match function of the keystroke mapper
package ttk_pkg;

	localparam int LIM_W = 9;

	localparam logic [1:0] OP_XLATE    = 2'd0;
	localparam logic [1:0] OP_LD_ASCII = 2'd1;
	localparam logic [1:0] OP_LD_COMBO = 2'd2;
	localparam logic [1:0] OP_LD_UTF8  = 2'd3;

	localparam logic [1:0] REG_COMBO_COUNT = 2'd0;
	localparam logic [1:0] REG_ASCII_COUNT = 2'd1;
	localparam logic [1:0] REG_UTF8_COUNT  = 2'd2;

	typedef enum logic [2:0] {
		CMD_XLATE,
		CMD_LD_ASCII,
		CMD_LD_COMBO,
		CMD_LD_UTF8,
		CMD_DROP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  idx;
		logic [63:0] word;
		logic [31:0] text;
	} item_t;

	typedef struct packed {
		logic [7:0] key_code;
		logic [7:0] modifier_bits;
		logic       key_valid;
		logic [2:0] bytes_consumed;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		logic [LIM_W-1:0] combo_lim;
		logic [LIM_W-1:0] ascii_lim;
		logic [LIM_W-1:0] utf8_lim;
	} lim_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_COMBO,
		BK_ASCII_RD,
		BK_ASCII_CHK,
		BK_UTF8,
		BK_EMIT1,
		BK_EMIT2
	} bk_state_t;

	function automatic logic [2:0] match_len(input logic [31:0] pat, input logic [31:0] txt);
		logic [2:0] n;
		logic       stop;
		logic       miss;
		int         j;
		n = 3'd0;
		stop = 1'b0;
		miss = 1'b0;
		for (j = 0; j < 4; j++) begin
			if (!stop && !miss) begin
				if (pat[8*j +: 8] == 8'd0) begin
					stop = 1'b1;
				end else if (pat[8*j +: 8] != txt[8*j +: 8]) begin
					miss = 1'b1;
				end else begin
					n = n + 3'd1;
				end
			end
		end
		return miss ? 3'd0 : n;
	endfunction

endpackage

@@ src/ttk_ram.sv @@
// generic single write port ram with registered read
module ttk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/ttk_fifo.sv @@
// small register queue
module ttk_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ src/ttk_front.sv @@
// front end: accepts items, classifies them and stages them for the command queue
module ttk_front #(
	parameter int COMBO_ENTRIES = 64,
	parameter int ASCII_ENTRIES = 128,
	parameter int UTF8_ENTRIES  = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          opcode,
	input  logic [6:0]          entry_index,
	input  logic [63:0]         entry_word,
	input  logic [31:0]         text,
	output logic                q_push,
	output ttk_pkg::item_t      q_wdata,
	input  logic                q_full
);

	ttk_pkg::item_t item_s1;
	ttk_pkg::item_t item_d;
	logic           vld_s1;
	logic           accept;

	always_comb begin
		item_d.idx  = entry_index;
		item_d.word = entry_word;
		item_d.text = text;
		case (opcode)
			ttk_pkg::OP_XLATE: begin
				item_d.kind = ttk_pkg::CMD_XLATE;
			end
			ttk_pkg::OP_LD_ASCII: begin
				item_d.kind = (int'(entry_index) < ASCII_ENTRIES) ?
					ttk_pkg::CMD_LD_ASCII : ttk_pkg::CMD_DROP;
			end
			ttk_pkg::OP_LD_COMBO: begin
				item_d.kind = (int'(entry_index) < COMBO_ENTRIES) ?
					ttk_pkg::CMD_LD_COMBO : ttk_pkg::CMD_DROP;
			end
			ttk_pkg::OP_LD_UTF8: begin
				item_d.kind = (int'(entry_index) < UTF8_ENTRIES) ?
					ttk_pkg::CMD_LD_UTF8 : ttk_pkg::CMD_DROP;
			end
			default: begin
				item_d.kind = ttk_pkg::CMD_DROP;
			end
		endcase
	end

	assign full    = vld_s1 && q_full;
	assign accept  = push && !full;
	assign q_push  = vld_s1;
	assign q_wdata = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ src/ttk_back.sv @@
// back end: table writes, combination/ascii/utf-8 lookup and result emission
module ttk_back #(
	parameter int COMBO_ENTRIES = 64,
	parameter int ASCII_ENTRIES = 128,
	parameter int UTF8_ENTRIES  = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ttk_pkg::lim_t  lim,
	input  logic           q_empty,
	input  ttk_pkg::item_t q_rdata,
	output logic           q_pop,
	output logic           res_push,
	output ttk_pkg::res_t  res_wdata,
	input  logic           res_full
);

	localparam int CAW = (COMBO_ENTRIES > 1) ? $clog2(COMBO_ENTRIES) : 1;
	localparam int AAW = (ASCII_ENTRIES > 1) ? $clog2(ASCII_ENTRIES) : 1;
	localparam int UAW = (UTF8_ENTRIES > 1) ? $clog2(UTF8_ENTRIES) : 1;

	ttk_pkg::bk_state_t state_q;
	ttk_pkg::bk_state_t state_d;

	logic [ttk_pkg::LIM_W-1:0] addr_q;
	logic                      chk_q;
	logic [31:0]               text_q;
	logic [7:0]                key1_q;
	logic [7:0]                mod1_q;
	logic [7:0]                key2_q;
	logic [7:0]                mod2_q;
	logic [2:0]                len_q;
	logic                      valid_q;
	logic                      two_q;

	logic        combo_we;
	logic        ascii_we;
	logic        utf8_we;
	logic        combo_re;
	logic        ascii_re;
	logic        utf8_re;
	logic [63:0] combo_rdata;
	logic [15:0] ascii_rdata;
	logic [47:0] utf8_rdata;
	logic [2:0]  combo_len;
	logic [2:0]  utf8_mlen;
	logic        combo_hit;
	logic        utf8_hit;
	logic        combo_more;
	logic        utf8_more;
	logic        ascii_sel;
	logic        head_xlate;

	ttk_ram #(.WIDTH(64), .DEPTH(COMBO_ENTRIES)) u_combo_ram (
		.clk   (clk),
		.we    (combo_we),
		.waddr (CAW'(q_rdata.idx)),
		.wdata (q_rdata.word),
		.re    (combo_re),
		.raddr (addr_q[CAW-1:0]),
		.rdata (combo_rdata)
	);

	ttk_ram #(.WIDTH(16), .DEPTH(ASCII_ENTRIES)) u_ascii_ram (
		.clk   (clk),
		.we    (ascii_we),
		.waddr (AAW'(q_rdata.idx)),
		.wdata (q_rdata.word[15:0]),
		.re    (ascii_re),
		.raddr (AAW'(text_q[7:0])),
		.rdata (ascii_rdata)
	);

	ttk_ram #(.WIDTH(48), .DEPTH(UTF8_ENTRIES)) u_utf8_ram (
		.clk   (clk),
		.we    (utf8_we),
		.waddr (UAW'(q_rdata.idx)),
		.wdata (q_rdata.word[47:0]),
		.re    (utf8_re),
		.raddr (addr_q[UAW-1:0]),
		.rdata (utf8_rdata)
	);

	assign combo_len  = ttk_pkg::match_len(combo_rdata[31:0], text_q);
	assign utf8_mlen  = ttk_pkg::match_len(utf8_rdata[31:0], text_q);
	assign combo_hit  = chk_q && (combo_len != 3'd0);
	assign utf8_hit   = chk_q && (utf8_mlen != 3'd0);
	assign combo_more = addr_q < lim.combo_lim;
	assign utf8_more  = addr_q < lim.utf8_lim;
	assign ascii_sel  = {1'b0, text_q[7:0]} < lim.ascii_lim;
	assign head_xlate = !q_empty && (q_rdata.kind == ttk_pkg::CMD_XLATE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ttk_pkg::BK_IDLE: begin
				if (head_xlate) begin
					state_d = ttk_pkg::BK_COMBO;
				end
			end
			ttk_pkg::BK_COMBO: begin
				if (combo_hit) begin
					state_d = ttk_pkg::BK_EMIT1;
				end else if (!combo_more) begin
					state_d = ascii_sel ? ttk_pkg::BK_ASCII_RD : ttk_pkg::BK_UTF8;
				end
			end
			ttk_pkg::BK_ASCII_RD: begin
				state_d = ttk_pkg::BK_ASCII_CHK;
			end
			ttk_pkg::BK_ASCII_CHK: begin
				state_d = ttk_pkg::BK_EMIT1;
			end
			ttk_pkg::BK_UTF8: begin
				if (utf8_hit || !utf8_more) begin
					state_d = ttk_pkg::BK_EMIT1;
				end
			end
			ttk_pkg::BK_EMIT1: begin
				if (!res_full) begin
					state_d = two_q ? ttk_pkg::BK_EMIT2 : ttk_pkg::BK_IDLE;
				end
			end
			ttk_pkg::BK_EMIT2: begin
				if (!res_full) begin
					state_d = ttk_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = ttk_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		combo_we  = 1'b0;
		ascii_we  = 1'b0;
		utf8_we   = 1'b0;
		combo_re  = 1'b0;
		ascii_re  = 1'b0;
		utf8_re   = 1'b0;
		res_push  = 1'b0;
		res_wdata = '0;
		case (state_q)
			ttk_pkg::BK_IDLE: begin
				q_pop    = !q_empty;
				combo_we = !q_empty && (q_rdata.kind == ttk_pkg::CMD_LD_COMBO);
				ascii_we = !q_empty && (q_rdata.kind == ttk_pkg::CMD_LD_ASCII);
				utf8_we  = !q_empty && (q_rdata.kind == ttk_pkg::CMD_LD_UTF8);
			end
			ttk_pkg::BK_COMBO: begin
				combo_re = !combo_hit && combo_more;
			end
			ttk_pkg::BK_ASCII_RD: begin
				ascii_re = 1'b1;
			end
			ttk_pkg::BK_UTF8: begin
				utf8_re = !utf8_hit && utf8_more;
			end
			ttk_pkg::BK_EMIT1: begin
				res_push                 = !res_full;
				res_wdata.key_code       = key1_q;
				res_wdata.modifier_bits  = mod1_q;
				res_wdata.key_valid      = valid_q;
				res_wdata.bytes_consumed = len_q;
				res_wdata.last_of_run    = !two_q;
			end
			ttk_pkg::BK_EMIT2: begin
				res_push                 = !res_full;
				res_wdata.key_code       = key2_q;
				res_wdata.modifier_bits  = mod2_q;
				res_wdata.key_valid      = 1'b1;
				res_wdata.bytes_consumed = len_q;
				res_wdata.last_of_run    = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttk_pkg::BK_IDLE;
			addr_q  <= '0;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ttk_pkg::BK_COMBO && !combo_hit && combo_more) ||
			    (state_q == ttk_pkg::BK_UTF8 && !utf8_hit && utf8_more)) begin
				addr_q <= addr_q + 1'b1;
				chk_q  <= 1'b1;
			end else begin
				addr_q <= '0;
				chk_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ttk_pkg::BK_IDLE: begin
				if (head_xlate) begin
					text_q <= q_rdata.text;
				end
			end
			ttk_pkg::BK_COMBO: begin
				if (combo_hit) begin
					mod1_q  <= combo_rdata[39:32];
					key1_q  <= combo_rdata[47:40];
					mod2_q  <= combo_rdata[55:48];
					key2_q  <= combo_rdata[63:56];
					len_q   <= combo_len;
					valid_q <= 1'b1;
					two_q   <= 1'b1;
				end
			end
			ttk_pkg::BK_ASCII_CHK: begin
				len_q <= 3'd1;
				two_q <= 1'b0;
				if (ascii_rdata[15:8] != 8'd0) begin
					key1_q  <= ascii_rdata[15:8];
					mod1_q  <= ascii_rdata[7:0];
					valid_q <= 1'b1;
				end else begin
					key1_q  <= 8'd0;
					mod1_q  <= 8'd0;
					valid_q <= 1'b0;
				end
			end
			ttk_pkg::BK_UTF8: begin
				two_q <= 1'b0;
				if (utf8_hit) begin
					mod1_q  <= utf8_rdata[39:32];
					key1_q  <= utf8_rdata[47:40];
					len_q   <= utf8_mlen;
					valid_q <= 1'b1;
				end else begin
					key1_q  <= 8'd0;
					mod1_q  <= 8'd0;
					len_q   <= 3'd1;
					valid_q <= 1'b0;
				end
			end
			default: begin
				two_q <= two_q;
			end
		endcase
	end

endmodule

@@ src/text_to_keystroke_mapper_unit.sv @@
// top level of the text to keystroke mapper: front end, command queue, back end, result queue
// lookup: a translate item scans up to combo_count combination entries, then reads the ascii
// table when its first byte is below ascii_count, else scans up to utf8_count utf-8 entries;
// counts are clamped to table depth.
// throughput: one table entry is checked per cycle on the single read port of each table ram;
// a load item is written into its table when it is taken from the command queue.
// reset: clears control state and the count registers; tables are undefined until loaded.
module text_to_keystroke_mapper_unit #(
	parameter int COMBO_ENTRIES = 64,
	parameter int ASCII_ENTRIES = 128,
	parameter int UTF8_ENTRIES  = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [6:0]  entry_index,
	input  logic [63:0] entry_word,
	input  logic [7:0]  text_byte0,
	input  logic [7:0]  text_byte1,
	input  logic [7:0]  text_byte2,
	input  logic [7:0]  text_byte3,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  key_code,
	output logic [7:0]  modifier_bits,
	output logic        key_valid,
	output logic [2:0]  bytes_consumed,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int QDEPTH = 2;

	logic [6:0]     combo_count_q;
	logic [7:0]     ascii_count_q;
	logic [7:0]     utf8_count_q;
	ttk_pkg::lim_t  lim;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	ttk_pkg::item_t q_wdata;
	ttk_pkg::item_t q_rdata;
	logic           res_push;
	logic           res_full;
	ttk_pkg::res_t  res_wdata;
	ttk_pkg::res_t  res_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combo_count_q <= '0;
			ascii_count_q <= '0;
			utf8_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ttk_pkg::REG_COMBO_COUNT: begin
					combo_count_q <= cfg_data[6:0];
				end
				ttk_pkg::REG_ASCII_COUNT: begin
					ascii_count_q <= cfg_data;
				end
				ttk_pkg::REG_UTF8_COUNT: begin
					utf8_count_q <= cfg_data;
				end
				default: begin
					combo_count_q <= combo_count_q;
				end
			endcase
		end
	end

	// counts clamped to table depth
	always_comb begin
		lim.combo_lim = ({2'b0, combo_count_q} < ttk_pkg::LIM_W'(COMBO_ENTRIES)) ?
			{2'b0, combo_count_q} : ttk_pkg::LIM_W'(COMBO_ENTRIES);
		lim.ascii_lim = ({1'b0, ascii_count_q} < ttk_pkg::LIM_W'(ASCII_ENTRIES)) ?
			{1'b0, ascii_count_q} : ttk_pkg::LIM_W'(ASCII_ENTRIES);
		lim.utf8_lim = ({1'b0, utf8_count_q} < ttk_pkg::LIM_W'(UTF8_ENTRIES)) ?
			{1'b0, utf8_count_q} : ttk_pkg::LIM_W'(UTF8_ENTRIES);
	end

	ttk_front #(
		.COMBO_ENTRIES (COMBO_ENTRIES),
		.ASCII_ENTRIES (ASCII_ENTRIES),
		.UTF8_ENTRIES  (UTF8_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.entry_index (entry_index),
		.entry_word  (entry_word),
		.text        ({text_byte3, text_byte2, text_byte1, text_byte0}),
		.q_push      (q_push),
		.q_wdata     (q_wdata),
		.q_full      (q_full)
	);

	ttk_fifo #(.WIDTH($bits(ttk_pkg::item_t)), .DEPTH(QDEPTH)) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	ttk_back #(
		.COMBO_ENTRIES (COMBO_ENTRIES),
		.ASCII_ENTRIES (ASCII_ENTRIES),
		.UTF8_ENTRIES  (UTF8_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lim       (lim),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.res_push  (res_push),
		.res_wdata (res_wdata),
		.res_full  (res_full)
	);

	ttk_fifo #(.WIDTH($bits(ttk_pkg::res_t)), .DEPTH(QDEPTH)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign key_code       = res_rdata.key_code;
	assign modifier_bits  = res_rdata.modifier_bits;
	assign key_valid      = res_rdata.key_valid;
	assign bytes_consumed = res_rdata.bytes_consumed;
	assign last_of_run    = res_rdata.last_of_run;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from an empty queue");

	a_first_of_pair_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_of_run) |-> key_valid)
		else $error("first keystroke of a combination is not valid");

	a_advance_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (bytes_consumed != 3'd0 && bytes_consumed <= 3'd4))
		else $error("byte advance out of range");

endmodule

@@ tb/text_to_keystroke_mapper_unit_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the text to keystroke mapper: directed table, then random layouts and text
module text_to_keystroke_mapper_unit_test;

	localparam int COMBO_DEPTH = 64;
	localparam int ASCII_DEPTH = 128;
	localparam int UTF8_DEPTH = 128;
	localparam int DRAIN_CYCLES = COMBO_DEPTH + UTF8_DEPTH + 8;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 180;
	localparam int HOLD_CYCLES = 1000;
	localparam int DIR_N = 23;
	localparam int DIR_SPLIT = 13;
	localparam ttk_pkg::res_t NO_KEY = '{8'h00, 8'h00, 1'b0, 3'd1, 1'b1};
	localparam logic [7:0] ALPHABET [8] = '{8'h27, 8'h5E, 8'h60, 8'h61, 8'h65, 8'hC3, 8'hA9, 8'hE2};

	typedef struct packed {
		logic [1:0]    op;
		logic [6:0]    idx;
		logic [63:0]   word;
		logic [31:0]   text;
		logic          typed;
		ttk_pkg::res_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  opcode = ttk_pkg::OP_XLATE;
	logic [6:0]  entry_index = 7'd0;
	logic [63:0] entry_word = 64'd0;
	logic [7:0]  text_byte0 = 8'd0;
	logic [7:0]  text_byte1 = 8'd0;
	logic [7:0]  text_byte2 = 8'd0;
	logic [7:0]  text_byte3 = 8'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  key_code;
	logic [7:0]  modifier_bits;
	logic        key_valid;
	logic [2:0]  bytes_consumed;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = ttk_pkg::REG_COMBO_COUNT;
	logic [7:0]  cfg_data = 8'd0;

	bit [63:0] combo_tbl [COMBO_DEPTH];
	bit [15:0] ascii_tbl [ASCII_DEPTH];
	bit [47:0] utf8_tbl [UTF8_DEPTH];
	logic [6:0] combo_cnt = 7'd0;
	logic [7:0] ascii_cnt = 8'd0;
	logic [7:0] utf8_cnt = 8'd0;

	ttk_pkg::res_t keystrokes_due [$];
	int   mismatches = 0;
	int   cycles = 0;
	bit   send_idle = 1'b1;
	bit   stall_on = 1'b1;
	int   holds_asked = 0;
	int   holds_done = 0;
	int   hold_left = 0;

	stim_row_t dir_rows [DIR_N] = '{
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_KEY},
		'{ttk_pkg::OP_LD_COMBO, 7'd0,   64'h0400_2E02_0000_6160, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_COMBO, 7'd1,   64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_COMBO, 7'd2,   64'hFF81_80E1_21AC_82E2, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_COMBO, 7'd64,  64'h1111_2222_0000_0060, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_ASCII, 7'h41,  64'hFFFF_FFFF_FFFF_0402, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_ASCII, 7'h00,  64'h0000_0000_0000_00FF, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_ASCII, 7'h7F,  64'h0000_0000_0000_4C00, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_ASCII, 7'h61,  64'h0000_0000_0000_0420, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_UTF8,  7'd0,   64'hFFFF_0840_0000_A9C3, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_UTF8,  7'd1,   64'h0000_2D20_0094_80E2, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_LD_UTF8,  7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h0000_6160, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h21AC_82E2, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h22AC_82E2, 1'b1, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h0000_0041, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'hFFFF_FF7F, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h6463_6261, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h4141_A9C3, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'hFF94_80E2, 1'b0, NO_KEY},
		'{ttk_pkg::OP_XLATE,    7'd0,   64'h0000_0000_0000_0000, 32'h0000_00FF, 1'b1, NO_KEY}
	};

	text_to_keystroke_mapper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.entry_index(entry_index),
		.entry_word(entry_word),
		.text_byte0(text_byte0),
		.text_byte1(text_byte1),
		.text_byte2(text_byte2),
		.text_byte3(text_byte3),
		.empty(empty),
		.pop(pop),
		.key_code(key_code),
		.modifier_bits(modifier_bits),
		.key_valid(key_valid),
		.bytes_consumed(bytes_consumed),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// length of the pattern prefix that matches the window, zero when rejected
	function automatic int pattern_hit(input logic [31:0] pat, input logic [31:0] win);
		int k;
		for (k = 0; k < 4; k++) begin
			if (pat[8*k +: 8] == 8'h00)
				return k;
			if (pat[8*k +: 8] != win[8*k +: 8])
				return 0;
		end
		return 4;
	endfunction

	function automatic int predict_keys(input logic [31:0] win, output ttk_pkg::res_t first,
			output ttk_pkg::res_t second);
		int climit;
		int alimit;
		int ulimit;
		int i;
		int n;
		bit [63:0] e;
		bit [15:0] a;
		first = NO_KEY;
		second = NO_KEY;
		climit = (combo_cnt < COMBO_DEPTH) ? int'(combo_cnt) : COMBO_DEPTH;
		alimit = (ascii_cnt < ASCII_DEPTH) ? int'(ascii_cnt) : ASCII_DEPTH;
		ulimit = (utf8_cnt < UTF8_DEPTH) ? int'(utf8_cnt) : UTF8_DEPTH;
		for (i = 0; i < climit; i++) begin
			e = combo_tbl[i];
			n = pattern_hit(e[31:0], win);
			if (n > 0) begin
				first = '{e[47:40], e[39:32], 1'b1, 3'(n), 1'b0};
				second = '{e[63:56], e[55:48], 1'b1, 3'(n), 1'b1};
				return 2;
			end
		end
		if (int'(win[7:0]) < alimit) begin
			a = ascii_tbl[win[6:0]];
			if (a[15:8] != 8'h00)
				first = '{a[15:8], a[7:0], 1'b1, 3'd1, 1'b1};
			return 1;
		end
		for (i = 0; i < ulimit; i++) begin
			e = {16'h0000, utf8_tbl[i]};
			n = pattern_hit(e[31:0], win);
			if (n > 0) begin
				first = '{e[47:40], e[39:32], 1'b1, 3'(n), 1'b1};
				return 1;
			end
		end
		return 1;
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) != 0)
			return ALPHABET[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] rand_pattern();
		logic [31:0] p;
		int len;
		int k;
		p = $urandom();
		len = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, 4));
		for (k = 0; k < len; k++) begin
			p[8*k +: 8] = pick_byte();
			if (p[8*k +: 8] == 8'h00)
				p[8*k +: 8] = 8'h01;
		end
		if (len < 4)
			p[8*len +: 8] = 8'h00;
		return p;
	endfunction

	function automatic logic [63:0] rand_entry(input logic [1:0] op);
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case (op)
			ttk_pkg::OP_LD_COMBO, ttk_pkg::OP_LD_UTF8: w[31:0] = rand_pattern();
			ttk_pkg::OP_LD_ASCII: if ($urandom_range(0, 3) == 0) w[15:8] = 8'h00;
			default: ;
		endcase
		return w;
	endfunction

	// half the windows are built from loaded patterns so that matches and near misses are common
	function automatic logic [31:0] pick_window();
		logic [31:0] w;
		bit tail;
		int k;
		case ($urandom_range(0, 9))
			0, 1, 2: w = combo_tbl[$urandom_range(0, COMBO_DEPTH - 1)][31:0];
			3, 4: w = utf8_tbl[$urandom_range(0, UTF8_DEPTH - 1)][31:0];
			5, 6, 7: return {pick_byte(), pick_byte(), pick_byte(), 1'b0,
				7'($urandom_range(0, 127))};
			default: return $urandom();
		endcase
		tail = 1'b0;
		for (k = 0; k < 4; k++) begin
			if (w[8*k +: 8] == 8'h00)
				tail = 1'b1;
			if (tail)
				w[8*k +: 8] = pick_byte();
		end
		if ($urandom_range(0, 3) == 0)
			w[8*$urandom_range(0, 3) +: 8] = pick_byte();
		return w;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [6:0] idx, input logic [63:0] word,
			input logic [31:0] win, input logic typed, input ttk_pkg::res_t want);
		int n;
		ttk_pkg::res_t first;
		ttk_pkg::res_t second;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		entry_word <= word;
		text_byte0 <= win[7:0];
		text_byte1 <= win[15:8];
		text_byte2 <= win[23:16];
		text_byte3 <= win[31:24];
		@(posedge clk);
		while (full)
			@(posedge clk);
		case (op)
			ttk_pkg::OP_LD_ASCII: ascii_tbl[idx] = word[15:0];
			ttk_pkg::OP_LD_COMBO: if (idx < COMBO_DEPTH) combo_tbl[idx[5:0]] = word;
			ttk_pkg::OP_LD_UTF8: utf8_tbl[idx] = word[47:0];
			default: begin
				if (typed) begin
					keystrokes_due.push_back(want);
				end else begin
					n = predict_keys(win, first, second);
					keystrokes_due.push_back(first);
					if (n == 2)
						keystrokes_due.push_back(second);
				end
			end
		endcase
	endtask

	task automatic send_random();
		logic [1:0] op;
		case ($urandom_range(0, 9))
			7: op = ttk_pkg::OP_LD_ASCII;
			8: op = ttk_pkg::OP_LD_COMBO;
			9: op = ttk_pkg::OP_LD_UTF8;
			default: op = ttk_pkg::OP_XLATE;
		endcase
		send_item(op, 7'($urandom_range(0, 127)), rand_entry(op), pick_window(), 1'b0, NO_KEY);
	endtask

	task automatic write_reg(input logic [1:0] ri, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (ri)
			ttk_pkg::REG_COMBO_COUNT: combo_cnt = v[6:0];
			ttk_pkg::REG_ASCII_COUNT: ascii_cnt = v;
			ttk_pkg::REG_UTF8_COUNT: utf8_cnt = v;
			default: ;
		endcase
	endtask

	task automatic set_counts(input logic [7:0] c, input logic [7:0] a, input logic [7:0] u);
		write_reg(ttk_pkg::REG_COMBO_COUNT, c);
		write_reg(ttk_pkg::REG_ASCII_COUNT, a);
		write_reg(ttk_pkg::REG_UTF8_COUNT, u);
		cfg_valid <= 1'b0;
	endtask

	// loads give no result, so let the back end finish a possible last scan
	task automatic settle();
		push <= 1'b0;
		while (keystrokes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_result();
		ttk_pkg::res_t want;
		if (keystrokes_due.size() == 0) begin
			$error("key result transfer with nothing expected: key_code %0h", key_code);
			mismatches++;
			return;
		end
		want = keystrokes_due.pop_front();
		if (key_code !== want.key_code) begin
			$error("key_code: expected %0h, got %0h", want.key_code, key_code);
			mismatches++;
		end
		if (modifier_bits !== want.modifier_bits) begin
			$error("modifier_bits: expected %0h, got %0h", want.modifier_bits, modifier_bits);
			mismatches++;
		end
		if (key_valid !== want.key_valid) begin
			$error("key_valid: expected %0h, got %0h", want.key_valid, key_valid);
			mismatches++;
		end
		if (bytes_consumed !== want.bytes_consumed) begin
			$error("bytes_consumed: expected %0h, got %0h", want.bytes_consumed, bytes_consumed);
			mismatches++;
		end
		if (last_of_run !== want.last_of_run) begin
			$error("last_of_run: expected %0h, got %0h", want.last_of_run, last_of_run);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (pop && !empty)
			check_result();
		if (holds_done != holds_asked) begin
			holds_done = holds_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (stall_on && $urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(0, 10);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		int i;
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < DIR_N; i++) begin
			if (i == DIR_SPLIT) begin
				settle();
				set_counts(8'd3, 8'd128, 8'd2);
			end
			send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].word, dir_rows[i].text,
				dir_rows[i].typed, dir_rows[i].want);
		end
		// write every slot once so that no scan meets an unwritten entry
		for (i = 0; i < COMBO_DEPTH; i++)
			send_item(ttk_pkg::OP_LD_COMBO, 7'(i), rand_entry(ttk_pkg::OP_LD_COMBO),
				pick_window(), 1'b0, NO_KEY);
		for (i = 0; i < ASCII_DEPTH; i++)
			send_item(ttk_pkg::OP_LD_ASCII, 7'(i), rand_entry(ttk_pkg::OP_LD_ASCII),
				pick_window(), 1'b0, NO_KEY);
		for (i = 0; i < UTF8_DEPTH; i++)
			send_item(ttk_pkg::OP_LD_UTF8, 7'(i), rand_entry(ttk_pkg::OP_LD_UTF8),
				pick_window(), 1'b0, NO_KEY);
		for (p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: set_counts(8'd64, 8'd128, 8'd128);
				1: set_counts(8'hFF, 8'hFF, 8'hFF);
				2: set_counts(8'd0, 8'd0, 8'd0);
				3: set_counts(8'd4, 8'd128, 8'd4);
				5: set_counts(8'd1, 8'd1, 8'd1);
				default: set_counts(8'($urandom()), 8'($urandom()), 8'($urandom()));
			endcase
			send_idle = (p < 6) && (p != 1) && (p != 3);
			stall_on = (p < 6) && (p != 2) && (p != 3);
			if (p == 3)
				holds_asked++;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_random();
		end
		settle();
		if (mismatches == 0 && keystrokes_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ttk_pkg.sv
src/ttk_ram.sv
src/ttk_fifo.sv
src/ttk_front.sv
src/ttk_back.sv
src/text_to_keystroke_mapper_unit.sv
tb/text_to_keystroke_mapper_unit_test.sv
